// ===== sv/skt_pkg.sv =====
// skt_pkg: shared constants for the sorted key table.
// Request kinds, result status codes and default sizes.
// Depends on nothing.
`timescale 1ns / 1ps

package skt_pkg;

  // Default sizing
  localparam int CAPACITY_DEF  = 64;
  localparam int ITEM_BITS_DEF = 32;

  // Port widths
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 3;
  localparam int ITEM_W   = 32;
  localparam int COUNT_W  = 7;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_LOOKUP    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REWIND    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_READ_NEXT = 3'd5;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

endpackage

// ===== sv/sorted_key_table_unit.sv =====
// sorted_key_table_unit: ordered key table with search, insert, delete and cursor read.
// One key memory with a single read and a single write port, driven by a small sequencer.
// Depends on skt_pkg.
`timescale 1ns / 1ps

// Usage
//   Request beat: kind and item_value are taken at a rising edge with start high and
//   busy low. busy stays high while the request is worked on; no new beat is taken then.
//   Result beat: done is high for exactly one cycle with status, item_out, count_out,
//   is_full and was_last. The receiver cannot stall; it must take the beat that cycle.
//   A new request may be accepted during the cycle that done is high.
// Request steps (accept edge to done cycle)
//   clear, rewind, unused kinds, read next on an empty table: answered from idle.
//   read next: one registered memory read, then the result beat.
//   lookup: binary search of P probes, P at most ceil(log2(count+1)), each a read and a compare.
//   insert: the lookup, then later entries shift up one slot and the key is written;
//   when the key lands at the end of the table it is written with no shift.
//   delete: the lookup, then later entries shift down one slot;
//   nothing more is done when the last entry is removed.
//   Shifting moves one entry per cycle through the memory's read and write ports.
// Reset
//   rst (synchronous) empties the table and puts the cursor at the head. Memory
//   contents are not cleared; only entries below the count are ever read.

module sorted_key_table_unit #(
  parameter int CAPACITY  = skt_pkg::CAPACITY_DEF,
  parameter int ITEM_BITS = skt_pkg::ITEM_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [skt_pkg::KIND_W-1:0]   kind,
  input  logic [skt_pkg::ITEM_W-1:0]   item_value,
  output logic                         done,
  output logic [skt_pkg::STATUS_W-1:0] status,
  output logic [skt_pkg::ITEM_W-1:0]   item_out,
  output logic [skt_pkg::COUNT_W-1:0]  count_out,
  output logic                         is_full,
  output logic                         was_last
);

  // Stored key width: keys arrive on a 32-bit port
  localparam int KW = (ITEM_BITS < skt_pkg::ITEM_W) ? ITEM_BITS : skt_pkg::ITEM_W;
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);
  localparam logic [CW-1:0] TWO_C = CW'(2);

  // Sequencer states
  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_SEARCH_RD  = 3'd1;
  localparam logic [2:0] S_SEARCH_CMP = 3'd2;
  localparam logic [2:0] S_SHIFT      = 3'd3;
  localparam logic [2:0] S_PUT        = 3'd4;
  localparam logic [2:0] S_READ_OUT   = 3'd5;

  // Control registers
  logic [2:0]    state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] cursor, cursor_next;
  logic          done_next;
  logic          rd_more, rd_more_next;
  logic          pend, pend_next;

  // Working registers
  logic [CW-1:0]                 lo, lo_next;
  logic [CW-1:0]                 hi, hi_next;
  logic                          found, found_next;
  logic [skt_pkg::KIND_W-1:0]    op, op_next;
  logic [KW-1:0]                 key, key_next;
  logic [CW-1:0]                 rd_ptr, rd_ptr_next;
  logic [CW-1:0]                 wr_ptr, wr_ptr_next;
  logic [CW-1:0]                 stop_ptr, stop_ptr_next;
  logic                          dir_down, dir_down_next;
  logic [skt_pkg::STATUS_W-1:0]  status_r, status_next;
  logic [skt_pkg::ITEM_W-1:0]    item_r, item_next;
  logic                          last_r, last_next;

  // Key memory
  logic [KW-1:0] mem [CAPACITY];
  logic [KW-1:0] rd_data;
  logic [AW-1:0] mem_raddr;
  logic [AW-1:0] mem_waddr;
  logic [KW-1:0] mem_wdata;
  logic          mem_we;

  // Derived values
  logic [CW:0]   mid_sum;
  logic [CW-1:0] mid;
  logic [CW-1:0] rpos_raw;
  logic [CW-1:0] rpos_in;
  logic          rd_last;
  logic [KW-1:0] in_key;

  assign in_key  = item_value[KW-1:0];
  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[CW:1];

  // Read next position from the cursor
  assign rpos_raw = (cursor == '0) ? '0 : (cursor - ONE_C);
  assign rpos_in  = (rpos_raw >= count) ? '0 : rpos_raw;
  assign rd_last  = (({1'b0, lo} + {1'b0, ONE_C}) >= {1'b0, count});

  // Memory port steering
  always_comb begin
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = wr_ptr[AW-1:0];
    mem_wdata = rd_data;
    unique case (state)
      S_IDLE:      mem_raddr = rpos_in[AW-1:0];
      S_SEARCH_RD: mem_raddr = mid[AW-1:0];
      S_SHIFT: begin
        mem_raddr = rd_ptr[AW-1:0];
        mem_we    = pend;
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = lo[AW-1:0];
        mem_wdata = key;
      end
      default: mem_raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  // Sequencer
  always_comb begin
    state_next    = state;
    count_next    = count;
    cursor_next   = cursor;
    done_next     = 1'b0;
    rd_more_next  = rd_more;
    pend_next     = pend;
    lo_next       = lo;
    hi_next       = hi;
    found_next    = found;
    op_next       = op;
    key_next      = key;
    rd_ptr_next   = rd_ptr;
    wr_ptr_next   = wr_ptr;
    stop_ptr_next = stop_ptr;
    dir_down_next = dir_down;
    status_next   = status_r;
    item_next     = item_r;
    last_next     = last_r;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          op_next     = kind;
          key_next    = in_key;
          lo_next     = '0;
          hi_next     = count;
          found_next  = 1'b0;
          item_next   = skt_pkg::ITEM_W'(in_key);
          last_next   = 1'b0;
          status_next = skt_pkg::ST_OK;
          unique case (kind)
            skt_pkg::KIND_LOOKUP,
            skt_pkg::KIND_INSERT,
            skt_pkg::KIND_DELETE: state_next = S_SEARCH_RD;
            skt_pkg::KIND_CLEAR: begin
              count_next  = '0;
              cursor_next = '0;
              done_next   = 1'b1;
            end
            skt_pkg::KIND_REWIND: begin
              cursor_next = '0;
              done_next   = 1'b1;
            end
            skt_pkg::KIND_READ_NEXT: begin
              if (count == '0) begin
                status_next = skt_pkg::ST_EMPTY;
                cursor_next = '0;
                done_next   = 1'b1;
              end else begin
                lo_next    = rpos_in;
                state_next = S_READ_OUT;
              end
            end
            default: done_next = 1'b1;
          endcase
        end
      end

      S_READ_OUT: begin
        item_next   = skt_pkg::ITEM_W'(rd_data);
        last_next   = rd_last;
        cursor_next = rd_last ? '0 : (lo + TWO_C);
        done_next   = 1'b1;
        state_next  = S_IDLE;
      end

      S_SEARCH_CMP: begin
        // One compare per probe: lower bound search
        if (rd_data < key) begin
          lo_next = mid + ONE_C;
        end else begin
          hi_next = mid;
        end
        if (rd_data == key) begin
          found_next = 1'b1;
        end
        state_next = S_SEARCH_RD;
      end

      S_SEARCH_RD: begin
        if (lo != hi) begin
          state_next = S_SEARCH_CMP;
        end else begin
          // Search done, lo is the slot of the key
          unique case (op)
            skt_pkg::KIND_LOOKUP: begin
              status_next = found ? skt_pkg::ST_OK : skt_pkg::ST_NOT_FOUND;
              done_next   = 1'b1;
              state_next  = S_IDLE;
            end
            skt_pkg::KIND_INSERT: begin
              priority if (found) begin
                status_next = skt_pkg::ST_DUPLICATE;
                done_next   = 1'b1;
                state_next  = S_IDLE;
              end else if (count == CAP_C) begin
                status_next = skt_pkg::ST_FULL;
                done_next   = 1'b1;
                state_next  = S_IDLE;
              end else begin
                count_next = count + ONE_C;
                if ((cursor != '0) && (lo < cursor)) begin
                  cursor_next = cursor + ONE_C;
                end
                if (lo == count) begin
                  state_next = S_PUT;
                end else begin
                  dir_down_next = 1'b1;
                  rd_ptr_next   = count - ONE_C;
                  wr_ptr_next   = count;
                  stop_ptr_next = lo;
                  rd_more_next  = 1'b1;
                  pend_next     = 1'b0;
                  state_next    = S_SHIFT;
                end
              end
            end
            skt_pkg::KIND_DELETE: begin
              if (!found) begin
                status_next = skt_pkg::ST_NOT_FOUND;
                done_next   = 1'b1;
                state_next  = S_IDLE;
              end else begin
                count_next = count - ONE_C;
                if (cursor != '0) begin
                  priority if ((lo + ONE_C) < cursor) begin
                    cursor_next = cursor - ONE_C;
                  end else if (cursor >= count) begin
                    cursor_next = '0;
                  end
                end
                if ((lo + ONE_C) == count) begin
                  done_next  = 1'b1;
                  state_next = S_IDLE;
                end else begin
                  dir_down_next = 1'b0;
                  rd_ptr_next   = lo + ONE_C;
                  wr_ptr_next   = lo;
                  stop_ptr_next = count - ONE_C;
                  rd_more_next  = 1'b1;
                  pend_next     = 1'b0;
                  state_next    = S_SHIFT;
                end
              end
            end
            default: begin
              done_next  = 1'b1;
              state_next = S_IDLE;
            end
          endcase
        end
      end

      S_SHIFT: begin
        // Read one entry, write the previous one a slot over
        if (rd_more) begin
          if (rd_ptr == stop_ptr) begin
            rd_more_next = 1'b0;
          end else begin
            rd_ptr_next = dir_down ? (rd_ptr - ONE_C) : (rd_ptr + ONE_C);
          end
        end
        pend_next = rd_more;
        if (pend) begin
          wr_ptr_next = dir_down ? (wr_ptr - ONE_C) : (wr_ptr + ONE_C);
          if (!rd_more) begin
            if (dir_down) begin
              state_next = S_PUT;
            end else begin
              done_next  = 1'b1;
              state_next = S_IDLE;
            end
          end
        end
      end

      S_PUT: begin
        done_next  = 1'b1;
        state_next = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      cursor  <= '0;
      done    <= 1'b0;
      rd_more <= 1'b0;
      pend    <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      cursor  <= cursor_next;
      done    <= done_next;
      rd_more <= rd_more_next;
      pend    <= pend_next;
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    lo       <= lo_next;
    hi       <= hi_next;
    found    <= found_next;
    op       <= op_next;
    key      <= key_next;
    rd_ptr   <= rd_ptr_next;
    wr_ptr   <= wr_ptr_next;
    stop_ptr <= stop_ptr_next;
    dir_down <= dir_down_next;
    status_r <= status_next;
    item_r   <= item_next;
    last_r   <= last_next;
  end

  // Outputs
  assign busy      = (state != S_IDLE);
  assign status    = status_r;
  assign item_out  = item_r;
  assign was_last  = last_r;
  assign count_out = skt_pkg::COUNT_W'(count);
  assign is_full   = (count == CAP_C);

  // Checks
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while sequencer busy");

  a_clear_done: assert property (@(posedge clk) disable iff (rst)
      (start && !busy && kind == skt_pkg::KIND_CLEAR) |=> (done && count_out == '0))
    else $error("clear did not answer at once with an empty table");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst) cursor <= count)
    else $error("cursor beyond table end");

  a_busy_no_done: assert property (@(posedge clk) disable iff (rst) $rose(busy) |-> !done)
    else $error("result beat at start of multi-cycle request");

endmodule
